@@ rtl/core/fcpw_pkg.sv @@
// Package of shared types and constants for the fuzzy cell partition weight block.
`timescale 1ns / 1ps
package fcpw_pkg;
  localparam int MAX_ATOMS_DEF      = 32;
  localparam int SHARPEN_PASSES_DEF = 3;
  localparam int COORD_W            = 32;
  localparam int DIST_W             = 34;
  localparam int Q30_W              = 31;
  localparam int WEIGHT_W           = 48;
  localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic                command;
    logic [4:0]          atom_index;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  coord_z;
    logic [4:0]          owner_atom;
    logic [WEIGHT_W-1:0] prior_weight;
  } in_beat_t;

  typedef struct packed {
    logic [Q30_W-1:0]    partition_weight;
    logic [WEIGHT_W-1:0] scaled_weight;
    logic                error_flag;
  } out_beat_t;

  // Request to the shared sequential arithmetic unit.
  typedef enum logic [3:0] {
    OP_SQRT = 4'b0001,
    OP_DIV  = 4'b0010,
    OP_MUL  = 4'b0100,
    OP_NONE = 4'b1000
  } op_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [67:0] a;
    logic [67:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [67:0] y;
  } alu_rsp_t;
endpackage

@@ rtl/core/fcpw_alu.sv @@
// Shared multi-cycle unit: integer square root, division and multiplication, bit per cycle.
`timescale 1ns / 1ps
module fcpw_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  fcpw_pkg::alu_req_t req,
  output fcpw_pkg::alu_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  fcpw_pkg::op_t op_r, op_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [67:0] a_r, a_nxt;
  logic [67:0] b_r, b_nxt;
  logic [69:0] rem_r, rem_nxt;
  logic [67:0] acc_r, acc_nxt;
  logic        done_r, done_nxt;
  logic [69:0] trial;
  logic [69:0] shifted;

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    trial    = '0;
    shifted  = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      a_nxt    = req.a;
      b_nxt    = req.b;
      rem_nxt  = '0;
      acc_nxt  = '0;
      unique case (req.op)
        fcpw_pkg::OP_SQRT: cnt_nxt = 7'd34;
        fcpw_pkg::OP_DIV:  cnt_nxt = 7'd68;
        fcpw_pkg::OP_MUL:  cnt_nxt = 7'd68;
        default:           cnt_nxt = 7'd1;
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        fcpw_pkg::OP_SQRT: begin
          shifted = {rem_r[67:0], a_r[67:66]};
          trial   = {acc_r[67:0], 2'b01};
          if (shifted >= trial) begin
            rem_nxt = shifted - trial;
            acc_nxt = {acc_r[66:0], 1'b1};
          end else begin
            rem_nxt = shifted;
            acc_nxt = {acc_r[66:0], 1'b0};
          end
          a_nxt = {a_r[65:0], 2'b00};
        end
        fcpw_pkg::OP_DIV: begin
          shifted = {rem_r[68:0], a_r[67]};
          trial   = {2'b00, b_r};
          if (shifted >= trial) begin
            rem_nxt = shifted - trial;
            acc_nxt = {acc_r[66:0], 1'b1};
          end else begin
            rem_nxt = shifted;
            acc_nxt = {acc_r[66:0], 1'b0};
          end
          a_nxt = {a_r[66:0], 1'b0};
        end
        fcpw_pkg::OP_MUL: begin
          if (a_r[67]) acc_nxt = {acc_r[66:0], 1'b0} + b_r;
          else         acc_nxt = {acc_r[66:0], 1'b0};
          a_nxt = {a_r[66:0], 1'b0};
        end
        default: acc_nxt = acc_r;
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= fcpw_pkg::OP_NONE;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.y    = acc_r;
endmodule

@@ rtl/core/fcpw_seq.sv @@
// Sequencer: atom table, point distance memory, pair loop and result staging.
`timescale 1ns / 1ps
module fcpw_seq #(
  parameter int MAX_ATOMS      = fcpw_pkg::MAX_ATOMS_DEF,
  parameter int SHARPEN_PASSES = fcpw_pkg::SHARPEN_PASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcpw_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcpw_pkg::out_beat_t out_data,
  output fcpw_pkg::alu_req_t  req,
  input  fcpw_pkg::alu_rsp_t  rsp
);
  localparam int IW = $clog2(MAX_ATOMS);
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int PW = $clog2(SHARPEN_PASSES + 1);

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001, S_PD_RD  = 19'h00002, S_PD_SQ  = 19'h00004,
    S_PD_WR  = 19'h00008, S_I_INIT = 19'h00010, S_J_RD   = 19'h00020,
    S_J_SQ   = 19'h00040, S_J_MU   = 19'h00080, S_M2     = 19'h00100,
    S_M3     = 19'h00200, S_G      = 19'h00400, S_PROD   = 19'h00800,
    S_NEXT_J = 19'h01000, S_I_END  = 19'h02000, S_DIV    = 19'h04000,
    S_SC_A   = 19'h08000, S_SC_B   = 19'h10000, S_FIN    = 19'h20000,
    S_OUT    = 19'h40000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] count_r;
  logic [CW-1:0] n_eff;

  logic [31:0] mem_x [MAX_ATOMS];
  logic [31:0] mem_y [MAX_ATOMS];
  logic [31:0] mem_z [MAX_ATOMS];
  logic [33:0] mem_d [MAX_ATOMS];
  logic [31:0] xi_rd, yi_rd, zi_rd, xj_rd, yj_rd, zj_rd;
  logic [33:0] di_rd, dj_rd;
  logic [IW-1:0] rd_i, rd_j;
  logic          d_we;
  logic [33:0]   d_wdata;

  fcpw_pkg::in_beat_t item_r;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic [1:0]    sq_k_r, sq_k_nxt;
  logic [67:0]   acc_r, acc_nxt;
  logic [33:0]   rij_r, rij_nxt;
  logic [30:0]   m_r, m_nxt, m2_r, m2_nxt, prod_r, prod_nxt, own_r, own_nxt, pw_r, pw_nxt;
  logic          neg_r, neg_nxt, err_r, err_nxt;
  logic [36:0]   sum_r, sum_nxt;
  logic [67:0]   sa_r, sa_nxt;
  logic [47:0]   sw_r, sw_nxt;
  fcpw_pkg::alu_req_t req_c;

  logic signed [32:0] dif_pt, dif_aa;
  logic [32:0]  mag;
  logic [34:0]  dd;
  logic [33:0]  ddm;
  logic [32:0]  three_m;
  logic [30:0]  s_fac;
  logic [77:0]  sc_sum;

  assign n_eff = (32'(count_r) > 32'(MAX_ATOMS)) ? CW'(MAX_ATOMS) : CW'(count_r);
  assign rd_i  = i_r[IW-1:0];
  assign rd_j  = j_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.command == fcpw_pkg::CMD_LOAD &&
        32'(in_data.atom_index) < 32'(MAX_ATOMS)) begin
      mem_x[IW'(in_data.atom_index)] <= in_data.coord_x;
      mem_y[IW'(in_data.atom_index)] <= in_data.coord_y;
      mem_z[IW'(in_data.atom_index)] <= in_data.coord_z;
    end
    xi_rd <= mem_x[rd_i];
    yi_rd <= mem_y[rd_i];
    zi_rd <= mem_z[rd_i];
    xj_rd <= mem_x[rd_j];
    yj_rd <= mem_y[rd_j];
    zj_rd <= mem_z[rd_j];
  end

  always_ff @(posedge clk) begin
    if (d_we) mem_d[rd_i] <= d_wdata;
    di_rd <= mem_d[rd_i];
    dj_rd <= mem_d[rd_j];
  end

  always_comb begin
    unique case (sq_k_r)
      2'd0:    dif_pt = $signed({item_r.coord_x[31], item_r.coord_x}) - $signed({xi_rd[31], xi_rd});
      2'd1:    dif_pt = $signed({item_r.coord_y[31], item_r.coord_y}) - $signed({yi_rd[31], yi_rd});
      default: dif_pt = $signed({item_r.coord_z[31], item_r.coord_z}) - $signed({zi_rd[31], zi_rd});
    endcase
    unique case (sq_k_r)
      2'd0:    dif_aa = $signed({xj_rd[31], xj_rd}) - $signed({xi_rd[31], xi_rd});
      2'd1:    dif_aa = $signed({yj_rd[31], yj_rd}) - $signed({yi_rd[31], yi_rd});
      default: dif_aa = $signed({zj_rd[31], zj_rd}) - $signed({zi_rd[31], zi_rd});
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; pass_nxt = pass_r; sq_k_nxt = sq_k_r;
    acc_nxt = acc_r; rij_nxt = rij_r; m_nxt = m_r; m2_nxt = m2_r;
    prod_nxt = prod_r; own_nxt = own_r; pw_nxt = pw_r; neg_nxt = neg_r;
    err_nxt = err_r; sum_nxt = sum_r; sa_nxt = sa_r; sw_nxt = sw_r;
    req_c = '{start: 1'b0, op: fcpw_pkg::OP_NONE, a: '0, b: '0};
    d_we = 1'b0; d_wdata = rsp.y[33:0];
    mag = '0; dd = '0; ddm = '0; three_m = '0; s_fac = '0; sc_sum = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.command == fcpw_pkg::CMD_EVAL) begin
          i_nxt = '0; sq_k_nxt = '0; acc_nxt = '0; err_nxt = 1'b0;
          sum_nxt = '0; own_nxt = '0;
          state_nxt = (n_eff == '0) ? S_I_END : S_PD_RD;
        end
      end
      S_PD_RD: state_nxt = S_PD_SQ;
      S_PD_SQ: begin
        mag = dif_pt[32] ? 33'(-dif_pt) : 33'(dif_pt);
        req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL, a: 68'(mag), b: 68'(mag)};
        state_nxt = S_PD_WR;
      end
      S_PD_WR: begin
        if (rsp.done) begin
          if (sq_k_r == 2'd3) begin
            d_we = 1'b1;
            sq_k_nxt = '0; acc_nxt = '0;
            if (i_r + 1'b1 == n_eff) begin
              i_nxt = '0; state_nxt = S_I_INIT;
            end else begin
              i_nxt = i_r + 1'b1; state_nxt = S_PD_RD;
            end
          end else begin
            acc_nxt = acc_r + rsp.y;
            if (sq_k_r == 2'd2) begin
              req_c = '{start: 1'b1, op: fcpw_pkg::OP_SQRT, a: acc_r + rsp.y, b: '0};
              sq_k_nxt = 2'd3;
            end else begin
              sq_k_nxt = sq_k_r + 2'd1; state_nxt = S_PD_SQ;
            end
          end
        end
      end
      S_I_INIT: begin
        prod_nxt = fcpw_pkg::ONE_Q30; j_nxt = '0;
        state_nxt = (i_r == '0 && n_eff == CW'(1)) ? S_I_END :
                    (i_r == '0) ? S_NEXT_J : S_J_RD;
        if (i_r == '0) j_nxt = '1;
      end
      S_J_RD: begin sq_k_nxt = '0; acc_nxt = '0; state_nxt = S_J_SQ; end
      S_J_SQ: begin
        mag = dif_aa[32] ? 33'(-dif_aa) : 33'(dif_aa);
        req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL, a: 68'(mag), b: 68'(mag)};
        state_nxt = S_J_MU;
      end
      S_J_MU: begin
        if (rsp.done) begin
          if (sq_k_r == 2'd3) begin
            rij_nxt = rsp.y[33:0];
            dd  = {1'b0, di_rd} - {1'b0, dj_rd};
            neg_nxt = dd[34];
            ddm = dd[34] ? 34'(-dd) : dd[33:0];
            if (rsp.y[33:0] == '0) begin
              err_nxt = 1'b1; state_nxt = S_I_END;
            end else if (ddm >= rsp.y[33:0]) begin
              m_nxt = fcpw_pkg::ONE_Q30; pass_nxt = '0; state_nxt = S_M2;
              req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL,
                        a: 68'(fcpw_pkg::ONE_Q30), b: 68'(fcpw_pkg::ONE_Q30)};
            end else begin
              req_c = '{start: 1'b1, op: fcpw_pkg::OP_DIV, a: {4'b0, ddm, 30'b0},
                        b: 68'(rsp.y[33:0])};
              pass_nxt = '1; state_nxt = S_M2;
            end
          end else begin
            acc_nxt = acc_r + rsp.y;
            if (sq_k_r == 2'd2) begin
              req_c = '{start: 1'b1, op: fcpw_pkg::OP_SQRT, a: acc_r + rsp.y, b: '0};
              sq_k_nxt = 2'd3;
            end else begin
              sq_k_nxt = sq_k_r + 2'd1; state_nxt = S_J_SQ;
            end
          end
        end
      end
      S_M2: begin
        if (rsp.done) begin
          if (pass_r == '1) begin
            m_nxt = rsp.y[30:0]; pass_nxt = '0;
            req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL,
                      a: 68'(rsp.y[30:0]), b: 68'(rsp.y[30:0])};
          end else begin
            m2_nxt = rsp.y[60:30];
            req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL,
                      a: 68'(rsp.y[60:30]), b: 68'(m_r)};
            state_nxt = S_M3;
          end
        end
      end
      S_M3: begin
        if (rsp.done) begin
          three_m = 33'(m_r) + 33'({m_r, 1'b0});
          m_nxt = 31'((three_m - 33'(rsp.y[60:30])) >> 1);
          state_nxt = S_G;
        end
      end
      S_G: begin
        if (pass_r + 1'b1 == PW'(SHARPEN_PASSES)) begin
          s_fac = neg_r ? 31'((32'(fcpw_pkg::ONE_Q30) + 32'(m_r)) >> 1)
                        : 31'((32'(fcpw_pkg::ONE_Q30) - 32'(m_r)) >> 1);
          req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL, a: 68'(prod_r),
                    b: 68'(s_fac)};
          state_nxt = S_PROD;
        end else begin
          pass_nxt = pass_r + 1'b1;
          req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL, a: 68'(m_r), b: 68'(m_r)};
          state_nxt = S_M2;
        end
      end
      S_PROD: begin
        if (rsp.done) begin
          prod_nxt = rsp.y[60:30]; state_nxt = S_NEXT_J;
        end
      end
      S_NEXT_J: begin
        j_nxt = j_r + 1'b1;
        if (j_r + 1'b1 == i_r) j_nxt = j_r + CW'(2);
        if (j_nxt >= n_eff) state_nxt = S_I_END;
        else state_nxt = S_J_RD;
      end
      S_I_END: begin
        if (err_r || n_eff == '0) begin
          err_nxt = 1'b1; state_nxt = S_FIN;
        end else begin
          sum_nxt = sum_r + 37'(prod_r);
          if (5'(i_r) == item_r.owner_atom && 32'(i_r) < 32) own_nxt = prod_r;
          if (i_r + 1'b1 == n_eff) begin
            state_nxt = S_DIV;
          end else begin
            i_nxt = i_r + 1'b1; state_nxt = S_I_INIT;
          end
        end
      end
      S_DIV: begin
        if (sum_r == '0) begin
          err_nxt = 1'b1; state_nxt = S_FIN;
        end else begin
          req_c = '{start: 1'b1, op: fcpw_pkg::OP_DIV, a: {7'b0, own_r, 30'b0},
                    b: 68'(sum_r)};
          state_nxt = S_SC_A;
        end
      end
      S_SC_A: begin
        if (rsp.done) begin
          pw_nxt = rsp.y[30:0]; sq_k_nxt = '0;
          req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL, a: 68'(item_r.prior_weight[47:24]),
                    b: 68'(rsp.y[30:0])};
          state_nxt = S_SC_B;
        end
      end
      S_SC_B: begin
        if (rsp.done) begin
          if (sq_k_r == 2'd0) begin
            sa_nxt = rsp.y; sq_k_nxt = 2'd1;
            req_c = '{start: 1'b1, op: fcpw_pkg::OP_MUL,
                      a: 68'(item_r.prior_weight[23:0]), b: 68'(pw_r)};
          end else begin
            sc_sum = {sa_r[53:0], 24'b0} + 78'(rsp.y[53:0]);
            sw_nxt = sc_sum[77:30];
            state_nxt = S_OUT;
          end
        end
      end
      S_FIN: begin
        pw_nxt = '0; sw_nxt = '0; state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= 6'd1;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) count_r <= cfg_wdata;
    end
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    i_r <= i_nxt; j_r <= j_nxt; pass_r <= pass_nxt; sq_k_r <= sq_k_nxt;
    acc_r <= acc_nxt; rij_r <= rij_nxt; m_r <= m_nxt; m2_r <= m2_nxt;
    prod_r <= prod_nxt; own_r <= own_nxt; pw_r <= pw_nxt; neg_r <= neg_nxt;
    err_r <= err_nxt; sum_r <= sum_nxt; sa_r <= sa_nxt; sw_r <= sw_nxt;
  end

  assign req       = req_c;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{partition_weight: pw_r, scaled_weight: sw_r, error_flag: err_r};
endmodule

@@ rtl/core/fuzzy_cell_partition_weight.sv @@
// Top level of the fuzzy cell partition weight block.
// Channel  | Ports                              | Beat
// input    | in_valid, in_ready, in_data        | fcpw_pkg::in_beat_t
// result   | out_valid, out_ready, out_data     | fcpw_pkg::out_beat_t
// config   | cfg_we, cfg_wdata                  | atom_count
// A load beat is taken while the block is idle.
// An evaluate beat works through each atom and each ordered atom pair in turn, its pace set by the single bit-serial
// multiply, divide and square root unit (68, 68 and 34 steps per operation).
// Reset is synchronous; no memory clearing pass is run.
// The block accepts no beat while an evaluation runs or a result waits.
`timescale 1ns / 1ps
module fuzzy_cell_partition_weight #(
  parameter int MAX_ATOMS      = fcpw_pkg::MAX_ATOMS_DEF,
  parameter int SHARPEN_PASSES = fcpw_pkg::SHARPEN_PASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcpw_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcpw_pkg::out_beat_t out_data
);
  fcpw_pkg::alu_req_t req;
  fcpw_pkg::alu_rsp_t rsp;

  fcpw_seq #(.MAX_ATOMS(MAX_ATOMS), .SHARPEN_PASSES(SHARPEN_PASSES)) u_seq (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .req, .rsp
  );

  fcpw_alu u_alu (.clk, .rst_n, .req, .rsp);
endmodule
